// ===== rtl/utf8sd_pkg.sv =====
// Shared types, widths and helper functions for the UTF-8 stream decoder.
// No dependencies.
package utf8sd_pkg;

    localparam int BYTE_W            = 8;
    localparam int CP_W              = 31;
    localparam int LEN_W             = 3;
    localparam int LEAD_W            = 4;
    localparam int MAX_SEQ_BYTES_DEF = 6;

    localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
    localparam logic [5:0]        CONT_MASK   = 6'h3F;
    localparam logic [BYTE_W-1:0] LEAD_MASK   = 8'h7F;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [LEN_W-1:0] seq_bytes;
        logic             bad_lead;
    } t_result;

    // Count of leading ones in a byte (0..8).
    function automatic logic [LEAD_W-1:0] f_lead_ones(input logic [BYTE_W-1:0] b);
        logic [LEAD_W-1:0] n;
        logic              run;
        n   = '0;
        run = 1'b1;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            run = run & b[i];
            n   = n + {{(LEAD_W-1){1'b0}}, run};
        end
        return n;
    endfunction

endpackage

// ===== rtl/utf8sd_in_stage.sv =====
// Input word register of the UTF-8 stream decoder.
// Depends on utf8sd_pkg.
module utf8sd_in_stage
    import utf8sd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_out_free,
    output logic              o_stall,
    output logic              o_vld,
    output logic              o_consume,
    output logic [BYTE_W-1:0] o_byte
);

    logic              r_vld;
    logic              n_vld;
    logic [BYTE_W-1:0] r_byte;
    logic              load;

    assign o_consume = r_vld & i_out_free;
    assign o_stall   = r_vld & ~i_out_free;
    assign load      = i_valid & ~o_stall;

    always_comb begin
        n_vld = r_vld;
        if (load) begin
            n_vld = 1'b1;
        end else if (o_consume) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_byte;
        end
    end

    assign o_vld  = r_vld;
    assign o_byte = r_byte;

endmodule

// ===== rtl/utf8sd_decode.sv =====
// Sequence state and per-word decode logic of the UTF-8 stream decoder.
// Depends on utf8sd_pkg.
module utf8sd_decode
    import utf8sd_pkg::*;
#(
    parameter int MAX_SEQ_BYTES = MAX_SEQ_BYTES_DEF
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_emit,
    output t_result           o_res
);

    localparam int ACC_W = 5 * MAX_SEQ_BYTES + 1;
    localparam logic [LEAD_W-1:0] MAX_LEAD = LEAD_W'(MAX_SEQ_BYTES);

    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  n_acc;
    logic [LEN_W-1:0]  r_left;
    logic [LEN_W-1:0]  n_left;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  n_len;
    logic [LEAD_W-1:0] lead;
    logic [ACC_W-1:0]  acc_shift;

    assign lead      = f_lead_ones(i_byte);
    assign acc_shift = {r_acc[ACC_W-7:0], i_byte[5:0] & CONT_MASK};

    always_comb begin
        n_acc  = r_acc;
        n_left = r_left;
        n_len  = r_len;
        o_emit = 1'b0;
        o_res  = '{code_point: CP_W'(i_byte), seq_bytes: LEN_W'(1), bad_lead: 1'b0};
        if (r_left != '0) begin
            n_acc  = acc_shift;
            n_left = r_left - LEN_W'(1);
            if (r_left == LEN_W'(1)) begin
                o_emit           = 1'b1;
                o_res.code_point = CP_W'(acc_shift);
                o_res.seq_bytes  = r_len;
            end
        end else if (i_byte < ASCII_LIMIT) begin
            o_emit = 1'b1;
        end else if (lead == LEAD_W'(1)) begin
            o_emit           = 1'b1;
            o_res.code_point = CP_W'(i_byte[5:0] & CONT_MASK);
        end else if (lead > MAX_LEAD) begin
            o_emit         = 1'b1;
            o_res.bad_lead = 1'b1;
        end else begin
            n_acc  = ACC_W'(i_byte & (LEAD_MASK >> lead));
            n_len  = LEN_W'(lead);
            n_left = LEN_W'(lead - LEAD_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_left <= '0;
            r_len  <= '0;
        end else if (i_step) begin
            r_acc  <= n_acc;
            r_left <= n_left;
            r_len  <= n_len;
        end
    end

`ifndef SYNTHESIS
    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left < LEN_W'(MAX_SEQ_BYTES))
        else $error("bytes left exceeds sequence limit");

    a_open_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_left == '0 && n_left != '0) |=> (r_len == r_left + LEN_W'(1)))
        else $error("opened sequence length mismatch");

    a_emit_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_emit) |-> (o_res.seq_bytes != '0 &&
                                o_res.seq_bytes <= LEN_W'(MAX_SEQ_BYTES)))
        else $error("emitted length out of range");

    a_bad_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_emit && o_res.bad_lead) |-> (r_left == '0 &&
                                                  o_res.seq_bytes == LEN_W'(1)))
        else $error("bad lead not a one-byte result");
`endif

endmodule

// ===== rtl/utf8_stream_decoder_unit.sv =====
// UTF-8 stream decoder (legacy six-byte form), top level; uses utf8sd_pkg,
// utf8sd_in_stage and utf8sd_decode. One byte word is accepted per clock and
// the block sustains one byte per cycle while the result is not stalled; each
// byte passes an input register and the result register before its code point
// reaches the outputs. While no sequence is open, bytes below 0x80 and stray
// continuation bytes give a one-byte result; a lead with 2..MAX_SEQ_BYTES
// leading ones opens a sequence whose following bytes are not checked; a lead
// with more leading ones is returned raw with o_bad_lead set. Intermediate
// bytes give no result. A stalled result holds both registers, and the input
// stalls while the input register is full and the result cannot advance.
module utf8_stream_decoder_unit
    import utf8sd_pkg::*;
#(
    parameter int MAX_SEQ_BYTES = MAX_SEQ_BYTES_DEF
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_byte_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [CP_W-1:0]   o_code_point,
    output logic [LEN_W-1:0]  o_seq_bytes,
    output logic              o_bad_lead
);

    logic              out_free;
    logic              stage_vld;
    logic              consume;
    logic [BYTE_W-1:0] stage_byte;
    logic              emit;
    t_result           res;
    logic              r_out_vld;
    logic              n_out_vld;
    t_result           r_res;

    assign out_free = ~r_out_vld | ~i_out_stall;

    utf8sd_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .i_byte     (i_byte_in),
        .i_out_free (out_free),
        .o_stall    (o_in_stall),
        .o_vld      (stage_vld),
        .o_consume  (consume),
        .o_byte     (stage_byte)
    );

    utf8sd_decode #(
        .MAX_SEQ_BYTES (MAX_SEQ_BYTES)
    ) u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (consume),
        .i_byte  (stage_byte),
        .o_emit  (emit),
        .o_res   (res)
    );

    always_comb begin
        n_out_vld = r_out_vld;
        if (consume) begin
            n_out_vld = emit;
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && emit) begin
            r_res <= res;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_code_point = r_res.code_point;
    assign o_seq_bytes  = r_res.seq_bytes;
    assign o_bad_lead   = r_res.bad_lead;

`ifndef SYNTHESIS
    a_consume_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume |-> stage_vld)
        else $error("decode step without a held word");

    a_stall_holds_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_out_stall) |=> (r_out_vld && $stable(r_res)))
        else $error("stalled result changed");

    a_stall_blocks_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_out_stall) |-> !consume)
        else $error("decode advanced while result stalled");
`endif

endmodule
